@@ rtl/core/mmf_pkg.sv @@
// ----------------------------------------------------------------------------
// mmf_pkg
// shared types and constants of the moving median filter
// ----------------------------------------------------------------------------
`default_nettype none

package mmf_pkg;

    localparam int CFG_WIDTH = 6;

    typedef logic [CFG_WIDTH-1:0] cfg_word_t;

    localparam cfg_word_t WINDOW_LEN_RESET = 6'd5;

    typedef logic [2:0] mmf_state_t;

    localparam mmf_state_t ST_IDLE   = 3'd0;
    localparam mmf_state_t ST_REMOVE = 3'd1;
    localparam mmf_state_t ST_INSERT = 3'd2;
    localparam mmf_state_t ST_WALK   = 3'd3;
    localparam mmf_state_t ST_FINISH = 3'd4;

endpackage

`default_nettype wire

@@ rtl/core/moving_median_filter_unit.sv @@
// ----------------------------------------------------------------------------
// moving_median_filter_unit
// sliding window median over the newest samples of a block, result x2
// ----------------------------------------------------------------------------
// Usage:
//   sample channel: sample, last_in_block with sample_valid / sample_stall.
//   result channel: median_x2, block_end with median_valid / median_stall.
//   config channel: cfg_data with cfg_valid / cfg_ready, sets window_len;
//   write it only while the block is idle.
// The window is kept as a value-sorted row of cells, each tagged with its age.
// Per sample: an accept step, a remove step that drops the oldest entry once
// the row is full, an insert step for the new one, then a walk over the sorted
// row, one cell per cycle, counting cells inside the window until the upper
// middle rank is found, then a finish step that loads the output register.
// The walk stops at the median cell, at most the fill (MAX_WINDOW) cells in.
// A sample that gives no result goes back to idle after the insert step. A new
// sample is taken while a result still waits in the output register; a stalled
// receiver holds the next result in the finish step.
// Reset empties the window and sets window_len to 5.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_median_filter_unit #(
    parameter int MAX_WINDOW   = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           sample_valid,
    output logic                          sample_stall,
    input  wire signed [SAMPLE_WIDTH-1:0] sample,
    input  wire                           last_in_block,
    output logic                          median_valid,
    input  wire                           median_stall,
    output logic signed [SAMPLE_WIDTH:0]  median_x2,
    output logic                          block_end,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire mmf_pkg::cfg_word_t       cfg_data
);

    import mmf_pkg::*;

    localparam int KW = $clog2(MAX_WINDOW + 1);
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int IW = AW;
    localparam int OW = SAMPLE_WIDTH + 1;

    logic signed [SAMPLE_WIDTH-1:0] val_reg [MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] val_next [MAX_WINDOW];
    logic [AW-1:0]                  age_reg [MAX_WINDOW];
    logic [AW-1:0]                  age_next [MAX_WINDOW];

    mmf_state_t                     state_reg, state_next;
    logic [KW-1:0]                  count_reg, count_next;
    cfg_word_t                      wlen_reg;
    logic [KW-1:0]                  k_reg, k_next;
    logic signed [SAMPLE_WIDTH-1:0] smp_reg, smp_next;
    logic                           last_reg, last_next;
    logic [IW-1:0]                  idx_reg, idx_next;
    logic [KW-1:0]                  rank_reg, rank_next;
    logic signed [SAMPLE_WIDTH-1:0] lo_reg, lo_next;
    logic signed [OW-1:0]           med_reg, med_next;
    logic                           out_valid_reg, out_valid_next;
    logic signed [OW-1:0]           out_data_reg, out_data_next;
    logic                           out_end_reg, out_end_next;

    logic [KW-1:0]                  eff_len;
    logic [MAX_WINDOW-1:0]          rm_vec;
    logic [MAX_WINDOW-1:0]          below_mask;
    logic [MAX_WINDOW-1:0]          place;
    logic                           full;
    logic [KW-1:0]                  lo_rank, hi_rank;
    logic signed [SAMPLE_WIDTH-1:0] walk_val;
    logic [AW-1:0]                  walk_age;
    logic                           in_win;
    logic signed [SAMPLE_WIDTH-1:0] lo_sel;
    logic                           out_free;
    logic                           accept;

    assign cfg_ready    = 1'b1;
    assign sample_stall = (state_reg != ST_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign median_valid = out_valid_reg;
    assign median_x2    = out_data_reg;
    assign block_end    = out_end_reg;
    assign out_free     = !out_valid_reg || !median_stall;

    always_comb
    begin
        if (wlen_reg == '0)
            eff_len = KW'(1);
        else if (32'(wlen_reg) > MAX_WINDOW)
            eff_len = KW'(MAX_WINDOW);
        else
            eff_len = KW'(wlen_reg);
    end

    assign full       = (32'(count_reg) == MAX_WINDOW);
    assign lo_rank    = (k_reg - KW'(1)) >> 1;
    assign hi_rank    = k_reg >> 1;
    assign walk_val   = val_reg[idx_reg];
    assign walk_age   = age_reg[idx_reg];
    assign in_win     = (32'(walk_age) < 32'(k_reg));
    assign lo_sel     = (rank_reg == lo_rank) ? walk_val : lo_reg;
    assign below_mask = rm_vec - MAX_WINDOW'(1);

    always_comb
    begin
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            rm_vec[j] = full && (age_reg[j] == AW'(MAX_WINDOW - 1));
            place[j]  = (32'(j) >= 32'(count_reg)) || (val_reg[j] > smp_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        smp_next       = smp_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        rank_next      = rank_reg;
        lo_next        = lo_reg;
        med_next       = med_reg;
        out_data_next  = out_data_reg;
        out_end_next   = out_end_reg;
        out_valid_next = out_valid_reg && median_stall;
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            val_next[j] = val_reg[j];
            age_next[j] = age_reg[j];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    smp_next   = sample;
                    last_next  = last_in_block;
                    k_next     = eff_len;
                    state_next = ST_REMOVE;
                end
            end
            ST_REMOVE:
            begin
                // when the row is full, drop the oldest cell and close the gap
                if (rm_vec != '0)
                begin
                    for (int j = 0; j < MAX_WINDOW - 1; j++)
                    begin
                        if (!below_mask[j])
                        begin
                            val_next[j] = val_reg[j + 1];
                            age_next[j] = age_reg[j + 1];
                        end
                    end
                    count_next = count_reg - KW'(1);
                end
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                for (int j = 0; j < MAX_WINDOW; j++)
                begin
                    if (j > 0 && place[(j > 0) ? j - 1 : 0])
                    begin
                        val_next[j] = val_reg[(j > 0) ? j - 1 : 0];
                        age_next[j] = age_reg[(j > 0) ? j - 1 : 0] + AW'(1);
                    end
                    else if (place[j])
                    begin
                        val_next[j] = smp_reg;
                        age_next[j] = '0;
                    end
                    else
                    begin
                        age_next[j] = age_reg[j] + AW'(1);
                    end
                end
                count_next = count_reg + KW'(1);
                idx_next   = '0;
                rank_next  = '0;
                if (count_reg + KW'(1) >= k_reg)
                    state_next = ST_WALK;
                else
                begin
                    if (last_reg)
                        count_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                idx_next = idx_reg + IW'(1);
                if (in_win)
                begin
                    rank_next = rank_reg + KW'(1);
                    if (rank_reg == lo_rank)
                        lo_next = walk_val;
                    if (rank_reg == hi_rank)
                    begin
                        med_next   = OW'(lo_sel) + OW'(walk_val);
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = med_reg;
                    out_end_next   = last_reg;
                    if (last_reg)
                        count_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            wlen_reg      <= WINDOW_LEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                wlen_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        smp_reg      <= smp_next;
        last_reg     <= last_next;
        idx_reg      <= idx_next;
        rank_reg     <= rank_next;
        lo_reg       <= lo_next;
        med_reg      <= med_next;
        out_data_reg <= out_data_next;
        out_end_reg  <= out_end_next;
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            val_reg[j] <= val_next[j];
            age_reg[j] <= age_next[j];
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/mmf_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mmf_tb_pkg
// scoreboard for the moving median filter: keeps its own copy of the sample
// window and the window length, works out twice the median of every sample
// beat that fills the window into a queue, and compares result beats against
// that queue

package mmf_tb_pkg;

    import mmf_pkg::*;

    localparam int WINDOW_DEPTH = 32;

    typedef logic signed [15:0] sample_t;
    typedef logic signed [16:0] median_t;

    typedef struct packed {
        median_t median_x2;
        logic    block_end;
    } median_beat_t;

    class median_scoreboard;

        sample_t      window [WINDOW_DEPTH];
        int           fill;
        cfg_word_t    window_len;
        median_beat_t expected [$];
        int unsigned  errors;

        function new();
            foreach (window[i])
                window[i] = '0;
            fill       = 0;
            window_len = WINDOW_LEN_RESET;
            errors     = 0;
        endfunction

        function void set_window_len(input cfg_word_t value);
            window_len = value;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        // one accepted sample beat
        function void note_sample(input sample_t value, input logic last);
            int           k;
            int           i;
            int           j;
            int           v;
            int           m;
            int           vals [WINDOW_DEPTH];
            median_beat_t beat;
            if (window_len == 0)
                k = 1;
            else if (window_len > WINDOW_DEPTH)
                k = WINDOW_DEPTH;
            else
                k = int'(window_len);
            for (i = WINDOW_DEPTH - 1; i > 0; i--)
                window[i] = window[i-1];
            window[0] = value;
            if (fill < WINDOW_DEPTH)
                fill++;
            if (fill >= k)
            begin
                for (i = 0; i < k; i++)
                begin
                    v = int'(window[i]);
                    j = i;
                    while (j > 0 && vals[j-1] > v)
                    begin
                        vals[j] = vals[j-1];
                        j--;
                    end
                    vals[j] = v;
                end
                if (k % 2 == 1)
                    m = 2 * vals[k/2];
                else
                    m = vals[k/2 - 1] + vals[k/2];
                beat.median_x2 = median_t'(m);
                beat.block_end = last;
                expected.push_back(beat);
            end
            if (last)
                fill = 0;
        endfunction

        // one accepted result beat
        function void check_median(input median_t median_x2, input logic block_end);
            median_beat_t beat;
            if (expected.size() == 0)
            begin
                $error("unexpected result beat: median_x2 %0d block_end %0b",
                       $signed(median_x2), block_end);
                errors++;
                return;
            end
            beat = expected.pop_front();
            if (median_x2 !== beat.median_x2)
            begin
                $error("median_x2 mismatch: expected %0d, actual %0d",
                       $signed(beat.median_x2), $signed(median_x2));
                errors++;
            end
            if (block_end !== beat.block_end)
            begin
                $error("block_end mismatch: expected %0b, actual %0b",
                       beat.block_end, block_end);
                errors++;
            end
        endfunction

    endclass

endpackage

@@ tb/sv/moving_median_filter_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// moving_median_filter_unit_tb
// drives sample beats and window length writes into the median filter and
// checks every result beat against the scoreboard; directed corner blocks
// first, then random blocks over many window lengths with random idling on
// both channels, a long receiver hold-off and full drains between phases
// ----------------------------------------------------------------------------

module moving_median_filter_unit_tb;

    import mmf_pkg::*;
    import mmf_tb_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 450;
    localparam int HOLD_CYCLES   = 300;

    logic      clk;
    logic      rst_n         = 1'b0;
    logic      sample_valid  = 1'b0;
    logic      sample_stall;
    sample_t   sample        = '0;
    logic      last_in_block = 1'b0;
    logic      median_valid;
    logic      median_stall  = 1'b0;
    median_t   median_x2;
    logic      block_end;
    logic      cfg_valid     = 1'b0;
    logic      cfg_ready;
    cfg_word_t cfg_data      = WINDOW_LEN_RESET;

    bit steady       = 1'b0;
    bit hold_request = 1'b0;

    median_scoreboard board = new();

    cfg_word_t phase_lens [12] = '{6'd1, 6'd3, 6'd32, 6'd63, 6'd4, 6'd7,
                                   6'd2, 6'd33, 6'd16, 6'd6, 6'd12, 6'd5};

    moving_median_filter_unit #(
        .MAX_WINDOW   (WINDOW_DEPTH),
        .SAMPLE_WIDTH (16)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample        (sample),
        .last_in_block (last_in_block),
        .median_valid  (median_valid),
        .median_stall  (median_stall),
        .median_x2     (median_x2),
        .block_end     (block_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic push_sample(input sample_t value, input logic last);
        while (!steady && $urandom_range(0, 99) < 12)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid  <= 1'b1;
        sample        <= value;
        last_in_block <= last;
        do
            @(negedge clk);
        while (sample_stall);
        @(posedge clk);
        board.note_sample(value, last);
    endtask

    task automatic drain_results();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_window_len(input cfg_word_t value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        board.set_window_len(value);
    endtask

    function automatic sample_t pick_sample();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        else if (r <= 3)
            return sample_t'(int'($urandom_range(0, 15)) - 8);
        else
            return sample_t'($urandom());
    endfunction

    // result side: checks at the falling edge, stall changes at the rising edge
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (rst_n && median_valid && !median_stall)
                board.check_median(median_x2, block_end);
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                median_stall <= 1'b1;
                hold_left--;
            end
            else
                median_stall <= !steady && ($urandom_range(0, 99) < 12);
        end
    end

    initial
    begin
        #(5_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int        phase;
        int        n;
        int        keff;
        int        block_left;
        int        sent_random;
        cfg_word_t len;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short block, window never fills
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh0001, 1'b1);

        // full-scale block at the reset length
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh0000, 1'b0);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sh0001, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b1);

        // block stays open across a shorter and then a longer length
        push_sample(16'sd100, 1'b0);
        push_sample(-16'sd200, 1'b0);
        push_sample(16'sd300, 1'b0);
        write_window_len(6'd2);
        push_sample(-16'sd5, 1'b0);
        push_sample(16'sd7, 1'b0);
        write_window_len(6'd9);
        push_sample(16'sd4, 1'b0);
        push_sample(-16'sd4, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b1);

        // zero length behaves as one
        write_window_len(6'd0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7FFF, 1'b1);

        phase       = 0;
        block_left  = 0;
        sent_random = 0;
        while (sent_random < RANDOM_ITEMS)
        begin
            if (phase < 12)
                len = phase_lens[phase];
            else
                len = cfg_word_t'($urandom_range(0, 63));
            write_window_len(len);
            keff   = (len == 0) ? 1 : ((len > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(len));
            steady = (phase == 4);
            for (n = 0; n < 20 + keff; n++)
            begin
                if (block_left <= 0)
                begin
                    if ($urandom_range(0, 99) < 15)
                        block_left = $urandom_range(1, keff);
                    else
                        block_left = keff + $urandom_range(0, 2 * keff + 6);
                end
                if (phase == 1 && n == 10)
                    hold_request = 1'b1;
                if ($urandom_range(0, 59) == 0)
                    drain_results();
                push_sample(pick_sample(), block_left == 1);
                block_left--;
                sent_random++;
            end
            phase++;
        end
        steady = 1'b0;

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/mmf_pkg.sv
rtl/core/moving_median_filter_unit.sv
tb/sv/mmf_tb_pkg.sv
tb/sv/moving_median_filter_unit_tb.sv
